// ===== src/rasp_pkg.sv =====
// shared types and codes for the resp array stream parser
`default_nettype none

package rasp_pkg;

  // input transaction: command and message byte
  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } item_t;

  // result transaction: one event per input transaction
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  payload_byte;
    logic        last_of_element;
    logic [3:0]  error_code;
    logic [15:0] elements_remaining;
  } result_t;

  // commands
  localparam logic CMD_PARSE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // parse phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_ARR_SIZE  = 4'd1;
  localparam logic [3:0] PH_ARR_LF    = 4'd2;
  localparam logic [3:0] PH_ELEM      = 4'd3;
  localparam logic [3:0] PH_PROP_SIZE = 4'd4;
  localparam logic [3:0] PH_PROP_LF   = 4'd5;
  localparam logic [3:0] PH_PROP_DATA = 4'd6;
  localparam logic [3:0] PH_PROP_CR   = 4'd7;
  localparam logic [3:0] PH_PROP_END  = 4'd8;
  localparam logic [3:0] PH_PIC_SIZE  = 4'd9;
  localparam logic [3:0] PH_PIC_LF    = 4'd10;
  localparam logic [3:0] PH_PIC_DATA  = 4'd11;
  localparam logic [3:0] PH_PIC_CR    = 4'd12;
  localparam logic [3:0] PH_PIC_END   = 4'd13;

  // event kinds
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_BEGIN     = 3'd1;
  localparam logic [2:0] EV_PROP      = 3'd2;
  localparam logic [2:0] EV_PIC       = 3'd3;
  localparam logic [2:0] EV_EMPTY_PIC = 3'd4;
  localparam logic [2:0] EV_COMPLETE  = 3'd5;
  localparam logic [2:0] EV_ERROR     = 3'd6;
  localparam logic [2:0] EV_DROPPED   = 3'd7;

  // error codes
  localparam logic [3:0] ERR_OK          = 4'd0;
  localparam logic [3:0] ERR_START       = 4'd1;
  localparam logic [3:0] ERR_COUNT_ZERO  = 4'd2;
  localparam logic [3:0] ERR_NOT_DIGIT   = 4'd3;
  localparam logic [3:0] ERR_COUNT_END   = 4'd4;
  localparam logic [3:0] ERR_PROP_END    = 4'd5;
  localparam logic [3:0] ERR_ELEM_START  = 4'd6;
  localparam logic [3:0] ERR_SIZE_ZERO   = 4'd7;
  localparam logic [3:0] ERR_PIC_END     = 4'd8;
  localparam logic [3:0] ERR_TOO_LARGE   = 4'd9;

  // message characters
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

endpackage

`default_nettype wire

// ===== src/resp_array_stream_parser_core.sv =====
// top level of the resp array stream parser: input register, parse step, result register
//
//   channel  direction  handshake                    payload
//   item     in         item_valid / item_ready      rasp_pkg::item_t   (command, data_byte)
//   result   out        result_valid / result_ready  rasp_pkg::result_t (one per item)
//
// one result per input transaction; each item moves from input register to result register
// throughput one byte per cycle unless stalled; single parse step between the two registers
// rst clears the pipeline valids and the parser state to idle with no sticky error
// a stalled result holds the pipeline; item_ready follows result_ready combinationally
`default_nettype none

module resp_array_stream_parser_core #(
  parameter int COUNT_BITS = 16,
  parameter int LEN_BITS   = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output      logic              item_ready,
  input  wire rasp_pkg::item_t   item,
  output      logic              result_valid,
  input  wire logic              result_ready,
  output      rasp_pkg::result_t result
);

  // accumulator is wide enough for either limit
  localparam int ACC_BITS = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

  // input register
  logic            in_valid_q;
  rasp_pkg::item_t in_q;

  // parser state
  logic [3:0]            phase;
  logic [COUNT_BITS-1:0] elements_left;
  logic [ACC_BITS-1:0]   acc;
  logic [LEN_BITS-1:0]   content_left;
  logic [3:0]            sticky_error;

  logic [3:0]            phase_next;
  logic [COUNT_BITS-1:0] elements_left_next;
  logic [ACC_BITS-1:0]   acc_next;
  logic [LEN_BITS-1:0]   content_left_next;
  logic [3:0]            sticky_error_next;

  // result register
  logic              res_valid_q;
  rasp_pkg::result_t res_q;
  rasp_pkg::result_t step_result;

  logic advance;

  // the held byte moves on when the result slot is free or being emptied
  assign advance    = in_valid_q && (!res_valid_q || result_ready);
  assign item_ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (item_ready) begin
      in_valid_q <= item_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_q <= item;
    end
  end

  rasp_step #(
    .COUNT_BITS(COUNT_BITS),
    .LEN_BITS  (LEN_BITS),
    .ACC_BITS  (ACC_BITS)
  ) u_step (
    .item              (in_q),
    .phase             (phase),
    .elements_left     (elements_left),
    .acc               (acc),
    .content_left      (content_left),
    .sticky_error      (sticky_error),
    .phase_next        (phase_next),
    .elements_left_next(elements_left_next),
    .acc_next          (acc_next),
    .content_left_next (content_left_next),
    .sticky_error_next (sticky_error_next),
    .result            (step_result)
  );

  // parser state commits only when the byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rasp_pkg::PH_IDLE;
      elements_left <= '0;
      acc           <= '0;
      content_left  <= '0;
      sticky_error  <= rasp_pkg::ERR_OK;
    end else if (advance) begin
      phase         <= phase_next;
      elements_left <= elements_left_next;
      acc           <= acc_next;
      content_left  <= content_left_next;
      sticky_error  <= sticky_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (result_ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= step_result;
    end
  end

  assign result_valid = res_valid_q;
  assign result       = res_q;

endmodule

`default_nettype wire

// ===== src/rasp_digit.sv =====
// decimal digit accumulate with range check against count or length limit
`default_nettype none

module rasp_digit #(
  parameter int COUNT_BITS = 16,
  parameter int LEN_BITS   = 24,
  parameter int ACC_BITS   = 24
) (
  input  wire logic [ACC_BITS-1:0] acc,
  input  wire logic [7:0]          ch,
  input  wire logic                use_count_limit,
  output      logic                is_digit,
  output      logic                too_large,
  output      logic [ACC_BITS-1:0] acc_next
);

  localparam int NW = ACC_BITS + 4;
  localparam logic [NW-1:0] CountMax = {{(NW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
  localparam logic [NW-1:0] LenMax   = {{(NW-LEN_BITS){1'b0}}, {LEN_BITS{1'b1}}};

  logic [7:0]    digit;
  logic [NW-1:0] acc_w;
  logic [NW-1:0] sum;
  logic [NW-1:0] limit;

  always_comb begin
    digit    = ch - rasp_pkg::CH_ZERO;
    is_digit = (ch >= rasp_pkg::CH_ZERO) && (ch <= rasp_pkg::CH_NINE);
    acc_w    = NW'(acc);
    // times ten as two shifted copies
    sum      = (acc_w << 3) + (acc_w << 1) + NW'(digit[3:0]);
    limit    = use_count_limit ? CountMax : LenMax;
    too_large = sum > limit;
    acc_next  = sum[ACC_BITS-1:0];
  end

endmodule

`default_nettype wire

// ===== src/rasp_step.sv =====
// next-state and event logic for one message byte
`default_nettype none

module rasp_step #(
  parameter int COUNT_BITS = 16,
  parameter int LEN_BITS   = 24,
  parameter int ACC_BITS   = 24
) (
  input  wire rasp_pkg::item_t       item,
  input  wire logic [3:0]            phase,
  input  wire logic [COUNT_BITS-1:0] elements_left,
  input  wire logic [ACC_BITS-1:0]   acc,
  input  wire logic [LEN_BITS-1:0]   content_left,
  input  wire logic [3:0]            sticky_error,
  output      logic [3:0]            phase_next,
  output      logic [COUNT_BITS-1:0] elements_left_next,
  output      logic [ACC_BITS-1:0]   acc_next,
  output      logic [LEN_BITS-1:0]   content_left_next,
  output      logic [3:0]            sticky_error_next,
  output      rasp_pkg::result_t     result
);

  localparam int EXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [7:0]            ch;
  logic                  dig_ok;
  logic                  dig_over;
  logic [ACC_BITS-1:0]   dig_acc;
  logic [COUNT_BITS-1:0] el_dec;
  logic [LEN_BITS-1:0]   content_dec;
  logic [EXT_BITS-1:0]   el_ext;
  logic [2:0]            kind;
  logic [7:0]            pbyte;
  logic                  last;
  logic [3:0]            code;

  assign ch = item.data_byte;

  rasp_digit #(
    .COUNT_BITS(COUNT_BITS),
    .LEN_BITS  (LEN_BITS),
    .ACC_BITS  (ACC_BITS)
  ) u_digit (
    .acc            (acc),
    .ch             (ch),
    .use_count_limit(phase == rasp_pkg::PH_ARR_SIZE),
    .is_digit       (dig_ok),
    .too_large      (dig_over),
    .acc_next       (dig_acc)
  );

  assign el_dec      = elements_left - COUNT_BITS'(1);
  assign content_dec = content_left - LEN_BITS'(1);

  always_comb begin
    phase_next         = phase;
    elements_left_next = elements_left;
    acc_next           = acc;
    content_left_next  = content_left;
    sticky_error_next  = sticky_error;
    kind  = rasp_pkg::EV_NONE;
    pbyte = 8'd0;
    last  = 1'b0;
    code  = rasp_pkg::ERR_OK;

    if (item.command == rasp_pkg::CMD_CLEAR) begin
      phase_next         = rasp_pkg::PH_IDLE;
      elements_left_next = '0;
      acc_next           = '0;
      content_left_next  = '0;
      sticky_error_next  = rasp_pkg::ERR_OK;
    end else if (sticky_error != rasp_pkg::ERR_OK) begin
      kind = rasp_pkg::EV_DROPPED;
      code = sticky_error;
    end else begin
      unique case (phase)
        rasp_pkg::PH_ARR_SIZE, rasp_pkg::PH_PROP_SIZE, rasp_pkg::PH_PIC_SIZE: begin
          if (ch == rasp_pkg::CH_CR) begin
            if (phase == rasp_pkg::PH_ARR_SIZE) begin
              if (acc == '0) begin
                code = rasp_pkg::ERR_COUNT_ZERO;
              end else begin
                elements_left_next = acc[COUNT_BITS-1:0];
                acc_next           = '0;
                phase_next         = rasp_pkg::PH_ARR_LF;
              end
            end else if (phase == rasp_pkg::PH_PROP_SIZE) begin
              if (acc == '0) begin
                code = rasp_pkg::ERR_SIZE_ZERO;
              end else begin
                content_left_next = acc[LEN_BITS-1:0];
                acc_next          = '0;
                phase_next        = rasp_pkg::PH_PROP_LF;
              end
            end else begin
              // zero-size picture is legal
              content_left_next = acc[LEN_BITS-1:0];
              acc_next          = '0;
              phase_next        = rasp_pkg::PH_PIC_LF;
            end
          end else if (!dig_ok) begin
            code = rasp_pkg::ERR_NOT_DIGIT;
          end else if (dig_over) begin
            code = rasp_pkg::ERR_TOO_LARGE;
          end else begin
            acc_next = dig_acc;
          end
        end
        rasp_pkg::PH_ARR_LF: begin
          if (ch == rasp_pkg::CH_LF) phase_next = rasp_pkg::PH_ELEM;
          else code = rasp_pkg::ERR_COUNT_END;
        end
        rasp_pkg::PH_ELEM: begin
          acc_next = '0;
          if (ch == rasp_pkg::CH_DOLLAR) phase_next = rasp_pkg::PH_PROP_SIZE;
          else if (ch == rasp_pkg::CH_HASH) phase_next = rasp_pkg::PH_PIC_SIZE;
          else code = rasp_pkg::ERR_ELEM_START;
        end
        rasp_pkg::PH_PROP_LF: begin
          // stray bytes before lf are ignored
          if (ch == rasp_pkg::CH_LF) phase_next = rasp_pkg::PH_PROP_DATA;
        end
        rasp_pkg::PH_PIC_LF: begin
          if (ch == rasp_pkg::CH_LF) begin
            if (content_left == '0) begin
              kind       = rasp_pkg::EV_EMPTY_PIC;
              phase_next = rasp_pkg::PH_PIC_CR;
            end else begin
              phase_next = rasp_pkg::PH_PIC_DATA;
            end
          end
        end
        rasp_pkg::PH_PROP_DATA, rasp_pkg::PH_PIC_DATA: begin
          kind  = (phase == rasp_pkg::PH_PROP_DATA) ? rasp_pkg::EV_PROP : rasp_pkg::EV_PIC;
          pbyte = ch;
          content_left_next = content_dec;
          if (content_dec == '0) begin
            last       = 1'b1;
            phase_next = (phase == rasp_pkg::PH_PROP_DATA) ? rasp_pkg::PH_PROP_CR
                                                           : rasp_pkg::PH_PIC_CR;
          end
        end
        rasp_pkg::PH_PROP_CR, rasp_pkg::PH_PIC_CR: begin
          if (ch == rasp_pkg::CH_CR) begin
            phase_next = (phase == rasp_pkg::PH_PROP_CR) ? rasp_pkg::PH_PROP_END
                                                         : rasp_pkg::PH_PIC_END;
          end else begin
            code = (phase == rasp_pkg::PH_PROP_CR) ? rasp_pkg::ERR_PROP_END
                                                   : rasp_pkg::ERR_PIC_END;
          end
        end
        rasp_pkg::PH_PROP_END, rasp_pkg::PH_PIC_END: begin
          if (ch == rasp_pkg::CH_LF) begin
            elements_left_next = el_dec;
            if (el_dec == '0) begin
              kind       = rasp_pkg::EV_COMPLETE;
              phase_next = rasp_pkg::PH_IDLE;
            end else begin
              phase_next = rasp_pkg::PH_ELEM;
            end
          end else begin
            code = (phase == rasp_pkg::PH_PROP_END) ? rasp_pkg::ERR_PROP_END
                                                    : rasp_pkg::ERR_PIC_END;
          end
        end
        default: begin
          // idle and unused phase codes expect the star; any other byte is a start error
          if (ch == rasp_pkg::CH_STAR) begin
            kind       = rasp_pkg::EV_BEGIN;
            acc_next   = '0;
            phase_next = rasp_pkg::PH_ARR_SIZE;
          end else begin
            code = rasp_pkg::ERR_START;
          end
        end
      endcase

      if (code != rasp_pkg::ERR_OK) begin
        kind              = rasp_pkg::EV_ERROR;
        sticky_error_next = code;
      end
    end

    el_ext = EXT_BITS'(elements_left_next);
    result.event_kind         = kind;
    result.payload_byte       = pbyte;
    result.last_of_element    = last;
    result.error_code         = code;
    result.elements_remaining = el_ext[15:0];
  end

endmodule

`default_nettype wire

// ===== src/rasp_checker.sv =====
// port-level checks for the resp array stream parser and their bind
`default_nettype none

module rasp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire rasp_pkg::item_t   item,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire rasp_pkg::result_t result
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // waiting input transaction holds
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_ready) |=> (item_valid && $stable(item)))
    else $error("waiting input changed");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // error code exactly on error or dropped transactions
  a_code_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      ((result.error_code != rasp_pkg::ERR_OK) ==
       (result.event_kind == rasp_pkg::EV_ERROR || result.event_kind == rasp_pkg::EV_DROPPED)))
    else $error("error code does not match event");

  // payload and last flag only on byte events
  a_payload_kind: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.last_of_element || result.payload_byte != 8'd0)) |->
      (result.event_kind == rasp_pkg::EV_PROP || result.event_kind == rasp_pkg::EV_PIC))
    else $error("payload on a non-byte event");

endmodule

bind resp_array_stream_parser_core rasp_checker u_rasp_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .item        (item),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result      (result)
);

`default_nettype wire
